// ===== rtl/bbtty_pkg.sv =====
package bbtty_pkg;

  localparam int OpcodeW = 2;
  localparam int PortW   = 5;
  localparam int ByteW   = 8;
  localparam int CharW   = 7;
  localparam int CountW  = 4;

  // Opcodes of an input item.
  localparam logic [OpcodeW-1:0] OP_READ  = 2'd0;
  localparam logic [OpcodeW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpcodeW-1:0] OP_KEY   = 2'd2;

  // Device table indexes of the teletype ports.
  localparam logic [PortW-1:0] PORT_RX_A = 5'd2;
  localparam logic [PortW-1:0] PORT_RX_B = 5'd5;
  localparam logic [PortW-1:0] PORT_TX_A = 5'd10;
  localparam logic [PortW-1:0] PORT_TX_B = 5'd14;

  localparam logic [ByteW-1:0] IDLE_LEVEL   = 8'h80;
  localparam logic [ByteW-1:0] HIGH_BIT     = 8'h80;
  localparam logic [ByteW-1:0] UNMAPPED_RD  = 8'hFF;
  localparam logic [ByteW-1:0] SUPPRESS_CH  = 8'o224;

  localparam logic [CountW-1:0] CNT_ZERO = 4'd0;
  localparam logic [CountW-1:0] CNT_ONE  = 4'd1;
  localparam logic [CountW-1:0] CNT_RX_LAST = 4'd7;
  localparam logic [CountW-1:0] CNT_TX_LAST = 4'd8;
  localparam logic [CountW-1:0] CNT_TX_DONE = 4'd9;

  // Decoded strobes for one accepted item.
  typedef struct packed {
    logic rx_read;
    logic key_arrive;
    logic tx_write;
  } bbtty_ctl_t;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             char_valid;
    logic [CharW-1:0] char_out;
  } bbtty_res_t;

endpackage

// ===== rtl/bbtty_if.sv =====
interface bbtty_in_if
  import bbtty_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [OpcodeW-1:0] opcode;
  logic [PortW-1:0]   port;
  logic [ByteW-1:0]   write_data;
  logic [ByteW-1:0]   key_char;

  modport source (output valid, output opcode, output port, output write_data,
                  output key_char, input ready);
  modport sink (input valid, input opcode, input port, input write_data,
                input key_char, output ready);
endinterface

interface bbtty_out_if
  import bbtty_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic             char_valid;
  logic [CharW-1:0] char_out;

  modport source (output valid, output read_data, output char_valid,
                  output char_out, input ready);
  modport sink (input valid, input read_data, input char_valid,
                input char_out, output ready);
endinterface

// ===== rtl/bbtty_rx.sv =====
module bbtty_rx
  import bbtty_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bbtty_ctl_t       ctl,
  input  logic [ByteW-1:0] key_char,
  output logic             level
);

  logic              key_flag;
  logic [ByteW-1:0]  key_latch;
  logic [CountW-1:0] rx_bit_count;
  logic [ByteW-1:0]  rx_shift;

  // Start bit is low; an empty line idles high at count zero.
  always_comb begin
    if (rx_bit_count == CNT_ZERO) begin
      level = !key_flag;
    end else begin
      level = rx_shift[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_flag     <= 1'b0;
      key_latch    <= '0;
      rx_bit_count <= CNT_ZERO;
      rx_shift     <= '0;
    end else if (ctl.key_arrive) begin
      key_latch <= key_char;
      key_flag  <= 1'b1;
    end else if (ctl.rx_read) begin
      if (rx_bit_count == CNT_ZERO) begin
        if (key_flag) begin
          rx_shift     <= key_latch | HIGH_BIT;
          key_flag     <= 1'b0;
          rx_bit_count <= CNT_ONE;
        end
      end else if (rx_bit_count > CNT_RX_LAST) begin
        rx_bit_count <= CNT_ZERO;
      end else begin
        rx_bit_count <= rx_bit_count + CNT_ONE;
        rx_shift     <= {1'b0, rx_shift[ByteW-1:1]};
      end
    end
  end

endmodule

// ===== rtl/bbtty_tx.sv =====
module bbtty_tx
  import bbtty_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bbtty_ctl_t       ctl,
  input  logic             line,
  output logic             char_valid,
  output logic [CharW-1:0] char_out
);

  logic [CountW-1:0] tx_bit_count;
  logic [ByteW-1:0]  tx_shift;
  logic [ByteW-1:0]  shift_in;

  assign shift_in   = {line, tx_shift[ByteW-1:1]};
  assign char_valid = ctl.tx_write && (tx_bit_count == CNT_TX_LAST) &&
                      (shift_in != SUPPRESS_CH);
  assign char_out   = char_valid ? shift_in[CharW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_bit_count <= CNT_ZERO;
      tx_shift     <= '0;
    end else if (ctl.tx_write) begin
      if ((tx_bit_count == CNT_ZERO) && !line) begin
        tx_bit_count <= CNT_ONE;
      end else if (tx_bit_count == CNT_TX_LAST) begin
        tx_shift     <= shift_in;
        tx_bit_count <= CNT_TX_DONE;
      end else if (tx_bit_count > CNT_TX_LAST) begin
        tx_shift     <= '0;
        tx_bit_count <= CNT_ZERO;
      end else begin
        // A high level at count zero is taken as a data bit as well.
        tx_shift     <= shift_in;
        tx_bit_count <= tx_bit_count + CNT_ONE;
      end
    end
  end

endmodule

// ===== rtl/bbtty_outbuf.sv =====
module bbtty_outbuf
  import bbtty_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bbtty_res_t  res,
  bbtty_out_if.source out_ch,
  output logic        skid_full
);

  logic       out_valid;
  bbtty_res_t out_data;
  bbtty_res_t skid_data;
  logic       take;

  assign take = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else begin
        skid_full <= 1'b1;
        skid_data <= res;
      end
    end else if (take) begin
      if (skid_full) begin
        out_data  <= skid_data;
        skid_full <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_data  = out_data.read_data;
  assign out_ch.char_valid = out_data.char_valid;
  assign out_ch.char_out   = out_data.char_out;

endmodule

// ===== rtl/bit_banged_tty_port_core.sv =====
// Bit-banged teletype port core (8 data bits).
//
// in_ch carries one item per handshake: a port read, a port write whose bit 0
// is the line level, or a keyboard character arriving. out_ch returns exactly
// one result item for every accepted item: read_data for reads, and
// char_valid / char_out when a transmit write completes a character.
//
// The receive and transmit shift state and the output buffer all update at the
// accepting edge; the result goes to the output register, or to the skid
// register while the output register waits. One item can be accepted in every
// cycle, limited only by the two-entry output buffer (output register plus skid register).
//
// When the receiver stalls, one more item is taken into the skid register;
// after that in_ch.ready drops until out_ch drains. No result is dropped.
//
// Reset (synchronous, active high) clears the output buffer, the key flag
// (status reads back as printer ready only), the key latch and both bit
// counters and shift registers.
module bit_banged_tty_port_core
  import bbtty_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bbtty_in_if.sink  in_ch,
  bbtty_out_if.source out_ch
);

  logic       accept;
  logic       skid_full;
  logic       is_rx;
  logic       is_tx;
  logic       rx_level;
  logic       tx_char_valid;
  logic [CharW-1:0] tx_char_out;
  bbtty_ctl_t ctl;
  bbtty_res_t res;

  // A slot is free whenever the skid register is empty.
  assign in_ch.ready = !skid_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_rx = (in_ch.port == PORT_RX_A) || (in_ch.port == PORT_RX_B);
  assign is_tx = (in_ch.port == PORT_TX_A) || (in_ch.port == PORT_TX_B);

  // Decode the item into strobes for the two shift units. Wrong-direction
  // accesses and the unused opcode raise no strobe.
  always_comb begin
    ctl = '0;
    if (accept) begin
      unique case (in_ch.opcode)
        OP_READ:  ctl.rx_read    = is_rx;
        OP_WRITE: ctl.tx_write   = is_tx;
        OP_KEY:   ctl.key_arrive = 1'b1;
        default:  ctl            = '0;
      endcase
    end
  end

  bbtty_rx u_rx (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .key_char (in_ch.key_char),
    .level    (rx_level)
  );

  bbtty_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .line       (in_ch.write_data[0]),
    .char_valid (tx_char_valid),
    .char_out   (tx_char_out)
  );

  // Result of the current item. Reads of unmapped ports float high; a read
  // of a transmit port returns zero.
  always_comb begin
    res            = '0;
    res.char_valid = tx_char_valid;
    res.char_out   = tx_char_out;
    if (in_ch.opcode == OP_READ) begin
      if (is_rx) begin
        res.read_data = {rx_level, {(ByteW-1){1'b0}}};
      end else if (!is_tx) begin
        res.read_data = UNMAPPED_RD;
      end
    end
  end

  bbtty_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .res       (res),
    .out_ch    (out_ch),
    .skid_full (skid_full)
  );

  // The skid register only fills behind a waiting output register.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_ch.valid)
    else $error("skid register full while output register empty");

  // Every accepted item leaves a result pending at the next edge.
  a_accept_gives_result : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("accepted item produced no pending result");

  // A printed character only comes from a write, which returns no read data.
  a_char_no_read : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.char_valid) |-> (out_ch.read_data == '0))
    else $error("character emitted together with read data");

  // No character code is shown unless a character is emitted.
  a_char_zero : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.char_valid) |-> (out_ch.char_out == '0))
    else $error("character code nonzero without char_valid");

  // Reset empties the output buffer.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!out_ch.valid && in_ch.ready))
    else $error("output buffer not empty after reset");

endmodule

// ===== tb/tty_port_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the teletype port, predicts one result for every
// accepted item and compares each accepted result with the oldest prediction.
module tty_port_checker
  import bbtty_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bbtty_in_if         in_mon,
  bbtty_out_if        out_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned chars_printed
);

  localparam logic [ByteW-1:0] STATUS_RESET = 8'h01;
  localparam logic [ByteW-1:0] KEY_AVAIL    = 8'h10;
  localparam logic [ByteW-1:0] CHAR_MASK    = 8'h7F;
  localparam int unsigned      MAX_REPORTS  = 10;

  // Shadow copy of the port state.
  logic [ByteW-1:0]  tty_status;
  logic [ByteW-1:0]  kbd_latch;
  logic [CountW-1:0] rx_count;
  logic [ByteW-1:0]  rx_shreg;
  logic [CountW-1:0] tx_count;
  logic [ByteW-1:0]  tx_shreg;

  bbtty_res_t  tty_results_due[$];
  bbtty_res_t  predicted;
  bbtty_res_t  want;
  bbtty_res_t  got;
  int unsigned mismatches;
  int unsigned printed;

  task automatic predict_tty_result(input logic [OpcodeW-1:0] op,
                                    input logic [PortW-1:0]   prt,
                                    input logic [ByteW-1:0]   wdata,
                                    input logic [ByteW-1:0]   kchar,
                                    output bbtty_res_t        res);
    logic [ByteW-1:0] line;
    logic             is_rx;
    logic             is_tx;
    res   = '0;
    is_rx = (prt == PORT_RX_A) || (prt == PORT_RX_B);
    is_tx = (prt == PORT_TX_A) || (prt == PORT_TX_B);
    line  = wdata[0] ? HIGH_BIT : '0;
    case (op)
      OP_READ: begin
        if (is_rx) begin
          if (rx_count == CNT_ZERO) begin
            if ((tty_status & KEY_AVAIL) != '0) begin
              rx_shreg       = kbd_latch | HIGH_BIT;
              tty_status     = tty_status & ~KEY_AVAIL;
              rx_count       = CNT_ONE;
              res.read_data  = '0;
            end else begin
              res.read_data = IDLE_LEVEL;
            end
          end else begin
            res.read_data = rx_shreg[0] ? HIGH_BIT : '0;
            if (rx_count > CNT_RX_LAST) begin
              rx_count = CNT_ZERO;
            end else begin
              rx_count = rx_count + 1'b1;
              rx_shreg = rx_shreg >> 1;
            end
          end
        end else if (!is_tx) begin
          res.read_data = UNMAPPED_RD;
        end
      end
      OP_WRITE: begin
        if (is_tx) begin
          if (tx_count == CNT_ZERO && !wdata[0]) begin
            tx_count = CNT_ONE;
          end else if (tx_count == CNT_TX_LAST) begin
            tx_shreg = (tx_shreg >> 1) | line;
            if (tx_shreg != SUPPRESS_CH) begin
              res.char_valid = 1'b1;
              res.char_out   = tx_shreg[CharW-1:0] & CHAR_MASK[CharW-1:0];
            end
            tx_count = CNT_TX_DONE;
          end else if (tx_count > CNT_TX_LAST) begin
            tx_shreg = '0;
            tx_count = CNT_ZERO;
          end else begin
            tx_shreg = (tx_shreg >> 1) | line;
            tx_count = tx_count + 1'b1;
          end
        end
      end
      OP_KEY: begin
        kbd_latch  = kchar;
        tty_status = tty_status | KEY_AVAIL;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tty_status = STATUS_RESET;
      kbd_latch  = '0;
      rx_count   = CNT_ZERO;
      rx_shreg   = '0;
      tx_count   = CNT_ZERO;
      tx_shreg   = '0;
      tty_results_due.delete();
      mismatches = 0;
      printed    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.read_data  = out_mon.read_data;
        got.char_valid = out_mon.char_valid;
        got.char_out   = out_mon.char_out;
        if (tty_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result read_data=%02h char_valid=%0b char_out=%02h",
                     $realtime, got.read_data, got.char_valid, got.char_out);
        end else begin
          want = tty_results_due.pop_front();
          if (got.read_data !== want.read_data || got.char_valid !== want.char_valid ||
              got.char_out !== want.char_out) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected rd=%02h cv=%0b ch=%02h, got rd=%02h cv=%0b ch=%02h",
                       $realtime, want.read_data, want.char_valid, want.char_out,
                       got.read_data, got.char_valid, got.char_out);
          end
        end
        if (got.char_valid === 1'b1)
          printed++;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_tty_result(in_mon.opcode, in_mon.port, in_mon.write_data,
                           in_mon.key_char, predicted);
        tty_results_due.push_back(predicted);
      end
    end
    fail_count    <= mismatches;
    pending       <= unsigned'(tty_results_due.size());
    chars_printed <= printed;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Top of the teletype port testbench. It builds the clock and reset, drives
// port reads, port writes and key arrivals into the core, drains its results
// with random stalls, and gives the verdict. All prediction and checking is
// done by the checker instantiated next to the core.
module tb;
  import bbtty_pkg::*;

  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 10;
  localparam int unsigned NUM_ITEMS      = 1500;
  localparam int unsigned MAX_IDLE       = 16;
  // The receiver stops taking results for a long stretch when it has taken
  // this many results, so that the two-entry output buffer fills and the
  // core drops its input ready while items are still being offered.
  localparam int unsigned HOLD_AT_FIRST  = 300;
  localparam int unsigned HOLD_AT_SECOND = 1000;
  localparam int unsigned LONG_HOLD      = 400;
  // The core registers each result at its accepting edge, so a short drain suffices.
  localparam int unsigned DRAIN_CYCLES   = 10;
  // Longest legal quiet stretch is the long hold; allow it many times over.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // The fourth opcode value is not defined by the package; the core must
  // treat it as a no-op that still returns an all-zero result.
  localparam logic [OpcodeW-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bbtty_in_if  in_ch();
  bbtty_out_if out_ch();

  bit_banged_tty_port_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int unsigned fail_count;
  int unsigned pending;
  int unsigned chars_printed;

  tty_port_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .chars_printed (chars_printed)
  );

  int unsigned items_sent    = 0;
  int unsigned results_taken = 0;
  int unsigned key_frames    = 0;
  int unsigned print_frames  = 0;
  int unsigned quiet_cycles  = 0;
  // While steady is set, neither side idles, so back-to-back items and
  // results are exercised in stretches.
  bit          steady        = 1'b0;

  // Watchdog: any cycle without a handshake on either channel counts toward
  // the limit; a handshake on either side starts the count over.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one item after a random idle gap and waits until it is accepted.
  // With no gap, valid stays high and only the payload changes, so valid is
  // never lowered and raised in the same time step.
  task automatic send_item(input logic [OpcodeW-1:0] op, input logic [PortW-1:0] prt,
                           input logic [ByteW-1:0] wdata, input logic [ByteW-1:0] kchar);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.port       <= prt;
    in_ch.write_data <= wdata;
    in_ch.key_char   <= kchar;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [PortW-1:0] pick_rx_port();
    return $urandom_range(0, 1) ? PORT_RX_A : PORT_RX_B;
  endfunction

  function automatic logic [PortW-1:0] pick_tx_port();
    return $urandom_range(0, 1) ? PORT_TX_A : PORT_TX_B;
  endfunction

  // One completely random item: any opcode including the unused one, and a
  // port that is a teletype port half the time so that wrong-direction
  // accesses and misaligned frames show up often.
  task automatic send_noise();
    logic [PortW-1:0] prt;
    case ($urandom_range(0, 7))
      0:       prt = PORT_RX_A;
      1:       prt = PORT_RX_B;
      2:       prt = PORT_TX_A;
      3:       prt = PORT_TX_B;
      default: prt = PortW'($urandom_range(0, 31));
    endcase
    send_item(OpcodeW'($urandom_range(0, 3)), prt, ByteW'($urandom), ByteW'($urandom));
  endtask

  // Writes one character onto the transmit line: a start bit, nbits data
  // bits least significant first, and optionally the write that clears the
  // shift state afterward. The upper bits of each written byte are random,
  // since only bit 0 is the line level.
  task automatic send_tx_frame(input logic [ByteW-1:0] ch, input int unsigned nbits,
                               input bit with_clear);
    logic [ByteW-1:0] wdata;
    wdata    = ByteW'($urandom);
    wdata[0] = 1'b0;
    send_item(OP_WRITE, pick_tx_port(), wdata, ByteW'($urandom));
    for (int unsigned i = 0; i < nbits; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_noise();
      wdata    = ByteW'($urandom);
      wdata[0] = ch[i];
      send_item(OP_WRITE, pick_tx_port(), wdata, ByteW'($urandom));
    end
    if (with_clear)
      send_item(OP_WRITE, pick_tx_port(), ByteW'($urandom), ByteW'($urandom));
    print_frames++;
  endtask

  // A key arrives, then the receive ports are read nreads times. Nine reads
  // shift out the start bit and all eight data bits; fewer or more leave the
  // receiver mid-frame or hit the idle level.
  task automatic send_key_frame(input logic [ByteW-1:0] ch, input int unsigned nreads);
    send_item(OP_KEY, PortW'($urandom_range(0, 31)), ByteW'($urandom), ch);
    for (int unsigned i = 0; i < nreads; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_noise();
      send_item(OP_READ, pick_rx_port(), ByteW'($urandom), ByteW'($urandom));
    end
    key_frames++;
  endtask

  // Takes results with random stalls, and twice with one long hold-off.
  task automatic take_results();
    int unsigned stall;
    forever begin
      if (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_SECOND)
        stall = LONG_HOLD;
      else
        stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_taken++;
    end
  endtask

  initial begin
    logic [ByteW-1:0] ch;
    int unsigned      nbits;

    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_READ;
    in_ch.port       <= '0;
    in_ch.write_data <= '0;
    in_ch.key_char   <= '0;
    out_ch.ready     <= 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    fork
      take_results();
    join_none

    // Directed part. Unmapped ports read back all ones, an empty receiver
    // reads back the idle-high level, and wrong-direction accesses, writes
    // to unmapped ports and the unused opcode all leave the state alone.
    send_item(OP_READ, 5'd0, 8'h00, 8'h00);
    send_item(OP_READ, PORT_RX_A, 8'hFF, 8'hFF);
    send_item(OP_READ, PORT_TX_B, 8'h00, 8'h00);
    send_item(OP_WRITE, PORT_RX_B, 8'hFF, 8'h00);
    send_item(OP_WRITE, 5'd31, 8'h00, 8'hFF);
    send_item(OP_UNUSED, PORT_TX_A, 8'hFF, 8'hFF);
    // Two keys in a row: the second overwrites the latch, so an all-zero
    // character is shifted out with bit 7 forced high as its last bit.
    send_item(OP_KEY, 5'd0, 8'h00, 8'hFF);
    send_item(OP_KEY, 5'd31, 8'hFF, 8'h00);
    for (int i = 0; i < 9; i++)
      send_item(OP_READ, (i % 2 == 0) ? PORT_RX_A : PORT_RX_B, 8'h00, 8'h00);
    // The suppressed character is received but never printed, then the
    // clearing write returns the transmitter to count zero.
    send_tx_frame(SUPPRESS_CH, 8, 1'b1);
    // Idle-high quirk: a high line level at count zero is shifted in as data.
    send_item(OP_WRITE, PORT_TX_B, 8'hFF, 8'h00);

    // Random part. Most of it is well-formed frames with random content so
    // that both shifters go through all of their counts; the rest is noise
    // and frames cut short or read past their end.
    while (items_sent < NUM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ch    = ($urandom_range(0, 7) == 0) ? SUPPRESS_CH : ByteW'($urandom);
          nbits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
          send_tx_frame(ch, nbits, $urandom_range(0, 7) != 0);
        end
        4, 5, 6: begin
          send_key_frame(ByteW'($urandom),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 11) : 9);
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      endcase
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // Let the checker see the last acceptance, then wait for every predicted
    // result to come back before the final drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d key frames and %0d print frames, with noise.",
             items_sent, key_frames, print_frames);
    $display("Took %0d results, %0d of them printed characters, with two long stalls.",
             results_taken, chars_printed);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
